@@ sv/clvr_pkg.sv @@
// clvr_pkg: types, codes and rounding helpers for the Lotka-Volterra RK4 stepper.
// No dependencies; imported by the controller, datapath, top level and testbench.
package clvr_pkg;

  localparam int unsigned CfgW   = 60;
  localparam int unsigned CfgIdxW = 4;

  // ceil(2^39 / 3) split into two 19-bit halves; exact for quotients of 38-bit values
  localparam logic [18:0] Recip3Lo = 19'h2AAAB;
  localparam logic [18:0] Recip3Hi = 19'h55555;

  typedef enum logic [3:0] {
    REG_GOOD_FIRST  = 4'd0,
    REG_GOOD_SECOND = 4'd1,
    REG_BAD_FIRST   = 4'd2,
    REG_BAD_SECOND  = 4'd3,
    REG_STEP_SIZE   = 4'd4,
    REG_GOOD_STEPS  = 4'd5,
    REG_BAD_STEPS   = 4'd6,
    REG_THRESHOLD   = 4'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SKIP, OP_YEAR, OP_MS, OP_MC, OP_AC, OP_GR, OP_MG,
    OP_KR, OP_MH, OP_QS, OP_MF, OP_TS, OP_DL, OP_DH, OP_DQ, OP_PU, OP_FIN, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       sp;   // species being worked on
    logic [1:0] stg;  // RK stage, 0..3
  } dp_cmd_t;

  typedef struct packed {
    logic crash;
  } dp_stat_t;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] m;
    begin
      mag = v[63] ? 64'(-v) : 64'(v);
      m = (mag + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

@@ sv/clvr_ifs.sv @@
// clvr_in_if / clvr_out_if: valid-ready channels for input and result words.
// Depends on nothing but the field widths of the block.
interface clvr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [30:0] load_first;
  logic [30:0] load_second;
  modport source (output valid, kind, load_first, load_second, input ready);
  modport sink   (input valid, kind, load_first, load_second, output ready);
endinterface

interface clvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_first;
  logic signed [31:0] pop_second;
  logic               year_is_good;
  logic               crashed;
  modport source (output valid, pop_first, pop_second, year_is_good, crashed, input ready);
  modport sink   (input valid, pop_first, pop_second, year_is_good, crashed, output ready);
endinterface

@@ sv/clvr_ctrl.sv @@
// clvr_ctrl: sequencer for the RK4 step, owns the handshakes.
// Depends on clvr_pkg; drives clvr_dp through dp_cmd_t.
module clvr_ctrl
  import clvr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001, S_YEAR = 18'h00002, S_MS  = 18'h00004, S_MC  = 18'h00008,
    S_AC   = 18'h00010, S_GR   = 18'h00020, S_MG  = 18'h00040, S_KR  = 18'h00080,
    S_MH   = 18'h00100, S_QS   = 18'h00200, S_MF  = 18'h00400, S_TS  = 18'h00800,
    S_DL   = 18'h01000, S_DH   = 18'h02000, S_DQ  = 18'h04000, S_PU  = 18'h08000,
    S_FIN  = 18'h10000, S_OUT  = 18'h20000
  } state_t;

  state_t     state_r, state_nxt;
  logic       sp_r, sp_nxt;
  logic [1:0] stg_r, stg_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    stg_nxt   = stg_r;
    ov_nxt    = ov_r && !out_ready;
    cmd.op    = OP_NONE;
    cmd.sp    = sp_r;
    cmd.stg   = stg_r;
    unique case (state_r)
      S_IDLE: begin
        sp_nxt  = 1'b0;
        stg_nxt = 2'd0;
        if (in_valid) begin
          if (!in_kind) begin
            cmd.op = OP_LOAD;
            state_nxt = S_OUT;
          end else if (stat.crash) begin
            cmd.op = OP_SKIP;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        cmd.op = OP_YEAR;
        state_nxt = S_MS;
      end
      S_MS: begin cmd.op = OP_MS; state_nxt = S_MC; end
      S_MC: begin cmd.op = OP_MC; state_nxt = S_AC; end
      S_AC: begin cmd.op = OP_AC; state_nxt = S_GR; end
      S_GR: begin cmd.op = OP_GR; state_nxt = S_MG; end
      S_MG: begin cmd.op = OP_MG; state_nxt = S_KR; end
      S_KR: begin
        cmd.op = OP_KR;
        if (!sp_r) begin
          sp_nxt = 1'b1;
          state_nxt = S_MS;
        end else begin
          sp_nxt = 1'b0;
          state_nxt = (stg_r == 2'd3) ? S_MF : S_MH;
        end
      end
      S_MH: begin cmd.op = OP_MH; state_nxt = S_QS; end
      S_QS: begin
        cmd.op = OP_QS;
        if (!sp_r) begin
          sp_nxt = 1'b1;
          state_nxt = S_MH;
        end else begin
          sp_nxt = 1'b0;
          stg_nxt = stg_r + 2'd1;
          state_nxt = S_MS;
        end
      end
      S_MF: begin cmd.op = OP_MF; state_nxt = S_TS; end
      S_TS: begin cmd.op = OP_TS; state_nxt = S_DL; end
      S_DL: begin cmd.op = OP_DL; state_nxt = S_DH; end
      S_DH: begin cmd.op = OP_DH; state_nxt = S_DQ; end
      S_DQ: begin cmd.op = OP_DQ; state_nxt = S_PU; end
      S_PU: begin
        cmd.op = OP_PU;
        if (!sp_r) begin
          sp_nxt = 1'b1;
          state_nxt = S_MF;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin cmd.op = OP_FIN; state_nxt = S_OUT; end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.op = OP_OUT;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= 1'b0;
      stg_r   <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      stg_r   <= stg_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ sv/clvr_dp.sv @@
// clvr_dp: registers, shared multiplier, divide-by-three unit and output word.
// Depends on clvr_pkg; sequenced by clvr_ctrl.
module clvr_dp
  import clvr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [30:0]         load_first,
  input  logic [30:0]         load_second,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  output logic signed [31:0]  pop_first,
  output logic signed [31:0]  pop_second,
  output logic                year_is_good,
  output logic                crashed
);

  localparam logic [1:0] YK_NONE = 2'd0;
  localparam logic [1:0] YK_GOOD = 2'd1;
  localparam logic [1:0] YK_BAD  = 2'd2;

  // configuration
  logic [59:0] gf_r, gs_r, bf_r, bs_r;
  logic [23:0] h_r, gsteps_r, bsteps_r;
  logic [30:0] thr_r;

  // state
  logic signed [31:0] p0_r, p1_r, q0_r, q1_r, g_r;
  logic signed [35:0] k0_r, k1_r;
  logic signed [39:0] s0_r, s1_r;
  logic signed [55:0] acc_r;
  logic signed [63:0] prod_r;
  logic [1:0]         yk_r;
  logic [23:0]        left_r;
  logic               crash_r, good_r, neg_r;
  logic [37:0]        tq_r;
  logic [37:0]        part_r;
  logic signed [31:0] o0_r, o1_r;
  logic               og_r, oc_r;

  // operand selection
  logic [59:0]        w;
  logic [19:0]        cr, cs, cc;
  logic signed [31:0] own, rival, pcur;
  logic signed [35:0] kcur;
  logic signed [39:0] scur;
  logic signed [39:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [72:0] mul_p;

  always_comb begin
    unique case ({good_r, cmd.sp})
      2'b10:   w = gf_r;
      2'b11:   w = gs_r;
      2'b00:   w = bf_r;
      default: w = bs_r;
    endcase
    cr    = w[19:0];
    cs    = w[39:20];
    cc    = w[59:40];
    pcur  = cmd.sp ? p1_r : p0_r;
    kcur  = cmd.sp ? k1_r : k0_r;
    scur  = cmd.sp ? s1_r : s0_r;
    if (cmd.stg == 2'd0) begin
      own   = pcur;
      rival = cmd.sp ? p0_r : p1_r;
    end else begin
      own   = cmd.sp ? q1_r : q0_r;
      rival = cmd.sp ? q0_r : q1_r;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MS: begin mul_a = {{8{own[31]}}, own};     mul_b = {13'd0, cs}; end
      OP_MC: begin mul_a = {{8{rival[31]}}, rival}; mul_b = {13'd0, cc}; end
      OP_MG: begin mul_a = {{8{g_r[31]}}, g_r};     mul_b = {own[31], own}; end
      OP_MH: begin mul_a = {{4{kcur[35]}}, kcur};   mul_b = {9'd0, h_r}; end
      OP_MF: begin mul_a = scur;                    mul_b = {9'd0, h_r}; end
      OP_DL: begin mul_a = {2'b00, tq_r};           mul_b = {14'd0, Recip3Lo}; end
      OP_DH: begin mul_a = {2'b00, tq_r};           mul_b = {14'd0, Recip3Hi}; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // derived values
  logic signed [63:0] kr64, q24, q25, gr64;
  logic signed [35:0] kv;
  logic signed [39:0] snew;
  logic signed [31:0] qv;
  logic [63:0]        pmag;
  logic [63:0]        dq_sum;
  logic signed [39:0] delta, np40;
  logic signed [31:0] np;
  logic [1:0]         yk_new;
  logic [23:0]        len_new;

  always_comb begin
    gr64 = rnd_sh({{8{acc_r[55]}}, acc_r}, 22);
    kr64 = rnd_sh(prod_r, 28);
    kv   = kr64[35:0];
    if (cmd.stg == 2'd0) snew = {{4{kv[35]}}, kv};
    else if (cmd.stg == 2'd3) snew = scur + {{4{kv[35]}}, kv};
    else snew = scur + {{3{kv[35]}}, kv, 1'b0};
    q24 = rnd_sh(prod_r, 24);
    q25 = rnd_sh(prod_r, 25);
    qv  = sat32({{32{pcur[31]}}, pcur} + ((cmd.stg == 2'd2) ? q24 : q25));
    pmag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    // x / 3 = (x * Recip3Hi + ((x * Recip3Lo) >> 19)) >> 20
    dq_sum = $unsigned(prod_r) + {26'd0, part_r};
    delta = neg_r ? -$signed({2'b00, tq_r}) : $signed({2'b00, tq_r});
    np40  = {{8{pcur[31]}}, pcur} + delta;
    np    = sat32({{24{np40[39]}}, np40});
    if (thr_r != 31'd0 && np < $signed({1'b0, thr_r})) np = 32'sd0;
    if (yk_r != YK_GOOD) begin
      yk_new  = YK_GOOD;
      len_new = (gsteps_r != 24'd0) ? gsteps_r : 24'd1;
    end else begin
      yk_new  = YK_BAD;
      len_new = (bsteps_r != 24'd0) ? bsteps_r : 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gf_r <= '0; gs_r <= '0; bf_r <= '0; bs_r <= '0;
      h_r <= 24'd83886; gsteps_r <= 24'd2400; bsteps_r <= 24'd5600; thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOOD_FIRST:  gf_r <= cfg_data;
        REG_GOOD_SECOND: gs_r <= cfg_data;
        REG_BAD_FIRST:   bf_r <= cfg_data;
        REG_BAD_SECOND:  bs_r <= cfg_data;
        REG_STEP_SIZE:   h_r <= cfg_data[23:0];
        REG_GOOD_STEPS:  gsteps_r <= cfg_data[23:0];
        REG_BAD_STEPS:   bsteps_r <= cfg_data[23:0];
        REG_THRESHOLD:   thr_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= '0; p1_r <= '0; yk_r <= YK_NONE; left_r <= '0;
      crash_r <= 1'b0; good_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          p0_r <= {1'b0, load_first};
          p1_r <= {1'b0, load_second};
          yk_r <= YK_NONE; left_r <= '0; crash_r <= 1'b0; good_r <= 1'b0;
        end
        OP_SKIP: good_r <= 1'b0;
        OP_YEAR: begin
          if (left_r == 24'd0) begin
            yk_r <= yk_new; left_r <= len_new; good_r <= (yk_new == YK_GOOD);
          end else begin
            good_r <= (yk_r == YK_GOOD);
          end
        end
        OP_PU: if (cmd.sp) p1_r <= np; else p0_r <= np;
        OP_FIN: begin
          left_r <= left_r - 24'd1;
          if (p0_r[31] || p1_r[31]) crash_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MS || cmd.op == OP_MC || cmd.op == OP_MG ||
        cmd.op == OP_MH || cmd.op == OP_MF || cmd.op == OP_DL || cmd.op == OP_DH)
      prod_r <= mul_p[63:0];
    unique case (cmd.op)
      OP_MC: acc_r <= $signed({6'd0, cr, 30'd0}) - prod_r[55:0];
      OP_AC: acc_r <= acc_r - prod_r[55:0];
      OP_GR: g_r <= sat32(gr64);
      OP_KR: begin
        if (cmd.sp) begin k1_r <= kv; s1_r <= snew; end
        else begin k0_r <= kv; s0_r <= snew; end
      end
      OP_QS: if (cmd.sp) q1_r <= qv; else q0_r <= qv;
      OP_TS: begin
        neg_r <= prod_r[63];
        tq_r  <= 38'((pmag + (64'd3 << 24)) >> 25);
      end
      OP_DH: part_r <= prod_r[56:19];
      OP_DQ: tq_r <= dq_sum[57:20];
      OP_OUT: begin o0_r <= p0_r; o1_r <= p1_r; og_r <= good_r; oc_r <= crash_r; end
      default: ;
    endcase
  end

  assign stat.crash   = crash_r;
  assign pop_first    = o0_r;
  assign pop_second   = o1_r;
  assign year_is_good = og_r;
  assign crashed      = oc_r;

endmodule

@@ sv/competitive_lotka_volterra_rk4_step.sv @@
// competitive_lotka_volterra_rk4_step: top level of the two-species RK4 stepper.
// Depends on clvr_pkg, clvr_ifs, clvr_ctrl and clvr_dp.
//
// Use: each input word is either a load (kind 0: set both Q11.20 populations,
// restart the good/bad year cycle, clear the crash flag) or a step (kind 1:
// one classic RK4 step of the competitive equations). Every input word gives
// exactly one result word with both populations, the year flag and the sticky
// crash flag. Coefficients, step size, year lengths and extinction threshold
// sit on the cfg_ write port and must be written while the block is idle.
// The block itself does not enforce this. A load or a step after a crash goes
// from the accept state to the output state, which writes the output register.
// A full step runs four derivative passes per species on the single shared
// multiplier, three stage updates per species, and per species a final weighted
// sum, a divide by three done as two reciprocal multiplies and an add, and the
// write-back, plus the accept, year, finish and output states.
// One word is worked on at a time; in_word.ready is high only when idle.
// The output register holds one result, so the next word is taken while a
// result waits; a step finishing against a stalled receiver waits for it.
// Reset (rst_n low, synchronous) clears populations, year state, crash flag
// and output valid, and restores the register defaults.
module competitive_lotka_volterra_rk4_step
  import clvr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  clvr_in_if.sink            in_word,
  clvr_out_if.source         out_word,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_kind   (in_word.kind),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  clvr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .load_first   (in_word.load_first),
    .load_second  (in_word.load_second),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pop_first    (out_word.pop_first),
    .pop_second   (out_word.pop_second),
    .year_is_good (out_word.year_is_good),
    .crashed      (out_word.crashed)
  );

endmodule

@@ sim/competitive_lotka_volterra_rk4_step_tb.sv @@
// Self-checking testbench for competitive_lotka_volterra_rk4_step: loads, RK4 steps,
// year cycling, extinction and crash handling, checked against an in-bench predictor.
// Depends on clvr_pkg, clvr_ifs and the block itself.
`timescale 1ns / 100ps

module competitive_lotka_volterra_rk4_step_tb;
  import clvr_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_WORDS = 1350;

  localparam int unsigned YEAR_NONE = 0;
  localparam int unsigned YEAR_GOOD = 1;
  localparam int unsigned YEAR_BAD = 2;

  typedef struct packed {
    logic signed [31:0] pop_first;
    logic signed [31:0] pop_second;
    logic               year_is_good;
    logic               crashed;
  } pop_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  clvr_in_if  in_if ();
  clvr_out_if out_if ();

  competitive_lotka_volterra_rk4_step u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if.sink),
    .out_word (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // register values to be written in the next configuration phase
  logic [59:0] reg_val [8];

  // predictor copy of configuration and state
  logic [59:0] eco_coef [4];   // good first, good second, bad first, bad second
  int unsigned eco_h, eco_good_len, eco_bad_len, eco_thr;
  int          eco_pop [2];
  int unsigned eco_year, eco_left;
  bit          eco_crash;

  pop_result_t expected_pops [$];

  int unsigned failures, n_loads, n_steps, n_good, n_crashed, n_phases;
  int unsigned burst_left;
  bit          sending_done;

  // ---------------------------------------------------------------- clock, reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // round to nearest, ties away from zero
  function automatic longint round_away(input longint v, input int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // one derivative pass for both species; set 0 good, 1 bad
  function automatic void growth_rates(input int pa, input int pb, input int set,
                                       output longint ka, output longint kb);
    longint acc, gr, sh, cr;
    int g, own, rival;
    logic [59:0] w;
    for (int i = 0; i < 2; i++) begin
      w = eco_coef[set * 2 + i];
      gr = longint'(w[19:0]);
      sh = longint'(w[39:20]);
      cr = longint'(w[59:40]);
      own = (i == 0) ? pa : pb;
      rival = (i == 0) ? pb : pa;
      acc = (gr <<< 30) - sh * longint'(own) - cr * longint'(rival);
      g = clip32(round_away(acc, 22));
      if (i == 0) ka = round_away(longint'(g) * longint'(own), 28);
      else kb = round_away(longint'(g) * longint'(own), 28);
    end
  endfunction

  function automatic void predict_word(input logic kind, input logic [30:0] la,
                                       input logic [30:0] lb);
    pop_result_t r;
    logic good;
    int set;
    int p [2];
    int q [2];
    longint k1 [2], k2 [2], k3 [2], k4 [2];
    longint sum, prod, mag, delta, dv;
    good = 1'b0;
    if (kind == KIND_LOAD) begin
      eco_pop[0] = int'({1'b0, la});
      eco_pop[1] = int'({1'b0, lb});
      eco_year = YEAR_NONE;
      eco_left = 0;
      eco_crash = 1'b0;
    end else if (!eco_crash) begin
      if (eco_left == 0) begin
        if (eco_year != YEAR_GOOD) begin
          eco_year = YEAR_GOOD;
          eco_left = (eco_good_len != 0) ? eco_good_len : 1;
        end else begin
          eco_year = YEAR_BAD;
          eco_left = (eco_bad_len != 0) ? eco_bad_len : 1;
        end
      end
      good = (eco_year == YEAR_GOOD);
      set = good ? 0 : 1;
      p = eco_pop;
      growth_rates(p[0], p[1], set, k1[0], k1[1]);
      for (int i = 0; i < 2; i++)
        q[i] = clip32(longint'(p[i]) + round_away(k1[i] * longint'(eco_h), 25));
      growth_rates(q[0], q[1], set, k2[0], k2[1]);
      for (int i = 0; i < 2; i++)
        q[i] = clip32(longint'(p[i]) + round_away(k2[i] * longint'(eco_h), 25));
      growth_rates(q[0], q[1], set, k3[0], k3[1]);
      for (int i = 0; i < 2; i++)
        q[i] = clip32(longint'(p[i]) + round_away(k3[i] * longint'(eco_h), 24));
      growth_rates(q[0], q[1], set, k4[0], k4[1]);
      dv = longint'(6) <<< 24;
      for (int i = 0; i < 2; i++) begin
        sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
        prod = sum * longint'(eco_h);
        mag = (prod < 0) ? -prod : prod;
        delta = (mag + dv / 2) / dv;
        if (prod < 0) delta = -delta;
        p[i] = clip32(longint'(p[i]) + delta);
        // extinction is applied before the crash check
        if (eco_thr != 0 && longint'(p[i]) < longint'(eco_thr)) p[i] = 0;
      end
      eco_left--;
      eco_pop = p;
      if (p[0] < 0 || p[1] < 0) eco_crash = 1'b1;
    end
    r.pop_first = eco_pop[0];
    r.pop_second = eco_pop[1];
    r.year_is_good = good;
    r.crashed = eco_crash;
    expected_pops.push_back(r);
  endfunction

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    pop_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pops.size() == 0) begin
        $display("%0t: result word with nothing expected: %h %h %b %b", $time,
                 out_if.pop_first, out_if.pop_second, out_if.year_is_good, out_if.crashed);
        failures++;
      end else begin
        exp_r = expected_pops.pop_front();
        if (out_if.pop_first !== exp_r.pop_first) begin
          $display("%0t: pop_first expected %h actual %h", $time, exp_r.pop_first,
                   out_if.pop_first);
          failures++;
        end
        if (out_if.pop_second !== exp_r.pop_second) begin
          $display("%0t: pop_second expected %h actual %h", $time, exp_r.pop_second,
                   out_if.pop_second);
          failures++;
        end
        if (out_if.year_is_good !== exp_r.year_is_good) begin
          $display("%0t: year_is_good expected %b actual %b", $time, exp_r.year_is_good,
                   out_if.year_is_good);
          failures++;
        end
        if (out_if.crashed !== exp_r.crashed) begin
          $display("%0t: crashed expected %b actual %b", $time, exp_r.crashed,
                   out_if.crashed);
          failures++;
        end
        if (exp_r.year_is_good) n_good++;
        if (exp_r.crashed) n_crashed++;
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls
  // pattern rotates through four phases: free, random, sparse, long stalls
  int unsigned rx_cyc;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 300) % 4)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= ($urandom_range(99) < 70);
      end
      2: begin
        out_if.ready <= (rx_cyc % 5 == 0);
      end
      default: begin
        out_if.ready <= ((rx_cyc % 64) >= 40);
      end
    endcase
  end

  // ---------------------------------------------------------------- watchdog
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver tasks
  // send one word; valid stays high inside a burst
  task automatic send_word(input logic kind, input logic [30:0] la, input logic [30:0] lb);
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.load_first <= la;
    in_if.load_second <= lb;
    do @(posedge clk); while (!in_if.ready);
    predict_word(kind, la, lb);
    if (kind == KIND_LOAD) n_loads++;
    else n_steps++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12);
      if ($urandom_range(3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // hold the sender until every expected word is back, then let the block settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all registers from reg_val; block must be idle
  task automatic apply_config();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= reg_val[i];
      @(posedge clk);
      case (cfg_reg_t'(i))
        REG_GOOD_FIRST: eco_coef[0] = reg_val[i];
        REG_GOOD_SECOND: eco_coef[1] = reg_val[i];
        REG_BAD_FIRST: eco_coef[2] = reg_val[i];
        REG_BAD_SECOND: eco_coef[3] = reg_val[i];
        REG_STEP_SIZE: eco_h = 32'(reg_val[i][23:0]);
        REG_GOOD_STEPS: eco_good_len = 32'(reg_val[i][23:0]);
        REG_BAD_STEPS: eco_bad_len = 32'(reg_val[i][23:0]);
        default: eco_thr = 32'(reg_val[i][30:0]);
      endcase
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_phases++;
  endtask

  function automatic logic [59:0] pack_coeffs(input logic [19:0] r, input logic [19:0] s,
                                              input logic [19:0] c);
    return {c, s, r};
  endfunction

  // plausible ecology: modest rates, small limits, short years
  function automatic void pick_mild_config();
    for (int i = 0; i < 4; i++)
      reg_val[i] = pack_coeffs(20'($urandom), 20'($urandom_range(4095)),
                               20'($urandom_range(4095)));
    reg_val[REG_STEP_SIZE] = 60'($urandom_range(1 << 14, 1 << 19));
    reg_val[REG_GOOD_STEPS] = 60'($urandom_range(1, 6));
    reg_val[REG_BAD_STEPS] = 60'($urandom_range(1, 6));
    reg_val[REG_THRESHOLD] = ($urandom_range(1) == 0) ? 60'd0 :
                             60'($urandom_range(1 << 16));
  endfunction

  function automatic logic [30:0] pick_population();
    if ($urandom_range(9) < 7) return 31'($urandom_range(1 << 18, 1 << 27));
    return 31'($urandom);
  endfunction

  // ---------------------------------------------------------------- tests
  // steps straight after reset run on zero populations with default registers
  task automatic test_reset_defaults();
    eco_coef = '{default: '0};
    eco_h = 83886;
    eco_good_len = 2400;
    eco_bad_len = 5600;
    eco_thr = 0;
    repeat (2) send_word(KIND_STEP, '0, '0);
    drain_results();
  endtask

  // good year of two steps, bad year of length zero acting as one
  task automatic test_year_cycle();
    pick_mild_config();
    reg_val[REG_GOOD_STEPS] = 60'd2;
    reg_val[REG_BAD_STEPS] = 60'd0;
    reg_val[REG_THRESHOLD] = 60'd0;
    apply_config();
    send_word(KIND_LOAD, 31'd1 << 22, 31'd3 << 20);
    repeat (6) send_word(KIND_STEP, '0, '0);
    drain_results();
  endtask

  // load extremes, extinction below threshold, and a crash that sticks until a load
  task automatic test_extremes();
    pick_mild_config();
    reg_val[REG_THRESHOLD] = 60'd1 << 20;
    apply_config();
    send_word(KIND_LOAD, 31'd1 << 19, 31'h7fffffff);
    send_word(KIND_STEP, '0, '0);
    send_word(KIND_LOAD, '0, 31'd1);
    send_word(KIND_STEP, '0, '0);
    drain_results();
    // harsh limits and the largest step: populations overshoot below zero
    for (int i = 0; i < 4; i++) reg_val[i] = pack_coeffs('0, 20'hfffff, 20'hfffff);
    reg_val[REG_STEP_SIZE] = 60'hffffff;
    reg_val[REG_THRESHOLD] = 60'd0;
    apply_config();
    send_word(KIND_LOAD, 31'd100 << 20, 31'd200 << 20);
    repeat (4) send_word(KIND_STEP, '0, '0);
    send_word(KIND_LOAD, 31'h7fffffff, 31'h7fffffff);
    repeat (3) send_word(KIND_STEP, '0, '0);
    drain_results();
    // huge threshold zeroes what would otherwise crash
    reg_val[REG_THRESHOLD] = 60'h7fffffff;
    apply_config();
    send_word(KIND_LOAD, 31'd100 << 20, 31'd200 << 20);
    repeat (2) send_word(KIND_STEP, '0, '0);
    drain_results();
  endtask

  // random phases, each with its own register setting; extremes at both ends
  task automatic test_random_phases();
    int unsigned per_phase;
    per_phase = RANDOM_WORDS / 9;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) begin
        reg_val = '{default: '0};
      end else if (ph == 8) begin
        for (int i = 0; i < 4; i++) reg_val[i] = {60{1'b1}};
        reg_val[REG_STEP_SIZE] = 60'hffffff;
        reg_val[REG_GOOD_STEPS] = 60'hffffff;
        reg_val[REG_BAD_STEPS] = 60'hffffff;
        reg_val[REG_THRESHOLD] = 60'd0;
      end else if (ph % 3 == 0) begin
        for (int i = 0; i < 4; i++) reg_val[i] = {28'($urandom), 32'($urandom)};
        reg_val[REG_STEP_SIZE] = 60'(24'($urandom));
        reg_val[REG_GOOD_STEPS] = 60'($urandom_range(1, 4));
        reg_val[REG_BAD_STEPS] = 60'($urandom_range(1, 4));
        reg_val[REG_THRESHOLD] = 60'(31'($urandom));
      end else begin
        pick_mild_config();
      end
      apply_config();
      for (int n = 0; n < per_phase; n++) begin
        if (n == 0 || $urandom_range(99) < 10)
          send_word(KIND_LOAD, pick_population(), pick_population());
        else
          send_word(KIND_STEP, 31'($urandom), 31'($urandom));
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_LOAD;
    in_if.load_first = '0;
    in_if.load_second = '0;
    out_if.ready = 1'b0;
    rx_cyc = 0;
    quiet_cycles = 0;
    failures = 0;
    burst_left = 0;
    eco_pop = '{0, 0};
    eco_year = YEAR_NONE;
    eco_left = 0;
    eco_crash = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_year_cycle();
    test_extremes();
    test_random_phases();

    drain_results();
    repeat (120) @(posedge clk);
    $display("Covered %0d loads and %0d steps over %0d register settings;", n_loads,
             n_steps, n_phases);
    $display("%0d results in good years, %0d with the crash flag set.", n_good, n_crashed);
    if (failures == 0 && expected_pops.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d words never returned", failures, expected_pops.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/clvr_pkg.sv
sv/clvr_ifs.sv
sv/clvr_ctrl.sv
sv/clvr_dp.sv
sv/competitive_lotka_volterra_rk4_step.sv
sim/competitive_lotka_volterra_rk4_step_tb.sv
